FILE: design/mwss_pkg.sv
// Shared definitions for the minimum window substring scan.
// Request codes and fixed field widths of the stream ports; no dependencies.
package mwss_pkg;

  // Request kinds carried on the input tuser.
  localparam logic [1:0] REQ_PATTERN = 2'd0;
  localparam logic [1:0] REQ_TEXT    = 2'd1;
  localparam logic [1:0] REQ_FINISH  = 2'd2;

  localparam int REQ_W      = 2;
  localparam int SYM_IN_W   = 7;
  localparam int SYM_CODES  = 1 << SYM_IN_W;
  localparam int IN_DATA_W  = 8;

  localparam int START_W    = 12;
  localparam int LENGTH_W   = 13;
  localparam int OUT_FIELDS_W = 1 + START_W + LENGTH_W + 1;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FIELDS_W;

endpackage

FILE: design/mwss_need_tab.sv
// Signed per-symbol need table with one read and one write port.
// A valid bit per entry lets a single clear pulse return every entry to zero.
module mwss_need_tab #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 14
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             clear,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic signed [WIDTH-1:0]          rd_data,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic signed [WIDTH-1:0]          wr_data
);

  logic signed [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0]        valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // An entry not written since the last clear reads as zero.
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

endmodule

FILE: design/min_window_substring_scan.sv
// Minimum window substring scan: pattern items fill a need table, text items
// slide a window and track the shortest covering span; finish reports it.
// A new item is taken only in idle. Each left-edge advance that a text item causes
// costs one text-store read and one need-table read and update, through the
// single need-table read port.
// Reset is synchronous; the table, counts and best window clear at once.
module min_window_substring_scan #(
  parameter int MAX_LEN  = 4096,
  parameter int ALPHABET = 128
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // symbol in bits [6:0], bit 7 zero
  input  logic [mwss_pkg::IN_DATA_W-1:0]  s_tdata,
  // req_type in bits [1:0]
  input  logic [mwss_pkg::REQ_W-1:0]      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // found [0], window_start [12:1], window_length [25:13], overflow [26], rest zero
  output logic [mwss_pkg::OUT_DATA_W-1:0] m_tdata
);
  import mwss_pkg::*;

  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int IDX_W  = $clog2(MAX_LEN);
  localparam int SYM_W  = $clog2(ALPHABET);
  localparam int NEED_W = LEN_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_P_UPD,
    ST_T_UPD,
    ST_L_SYM,
    ST_L_UPD
  } state_t;

  state_t state;

  logic [LEN_W-1:0] missing_count;
  logic [LEN_W-1:0] pattern_length;
  logic [LEN_W-1:0] left_edge;
  logic [LEN_W-1:0] right_edge;
  logic [IDX_W-1:0] best_start;
  logic [LEN_W-1:0] best_length;
  logic             best_valid;
  logic             overflow_flag;
  logic [SYM_W-1:0] cur_sym;
  logic [SYM_W-1:0] text_rd;

  logic [SYM_W-1:0] text_store [MAX_LEN];
  logic [SYM_W-1:0] sym_mod_tab [SYM_CODES];

  logic [SYM_IN_W-1:0]     sym_in;
  logic [SYM_W-1:0]        sym_red;
  logic                    accept;
  logic                    finish_acc;
  logic                    take_pat;
  logic                    take_txt;
  logic                    need_rd_en;
  logic [SYM_W-1:0]        need_rd_addr;
  logic signed [NEED_W-1:0] need_rd;
  logic                    need_wr_en;
  logic signed [NEED_W-1:0] need_wr_data;
  logic [LEN_W-1:0]        missing_next;
  logic                    scan_go;
  logic [LEN_W-1:0]        span;
  logic                    found;

  // Symbol reduction modulo the alphabet size as a constant lookup.
  for (genvar g = 0; g < SYM_CODES; g++) begin : g_mod
    assign sym_mod_tab[g] = SYM_W'(g % ALPHABET);
  end

  assign sym_in     = s_tdata[SYM_IN_W-1:0];
  assign sym_red    = sym_mod_tab[sym_in];
  assign s_tready   = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept     = s_tvalid && s_tready;
  assign finish_acc = accept && (s_tuser == REQ_FINISH);
  assign take_pat = accept && (s_tuser == REQ_PATTERN) && (pattern_length < LEN_W'(MAX_LEN));
  assign take_txt = accept && (s_tuser == REQ_TEXT) && (right_edge < LEN_W'(MAX_LEN));
  assign span     = right_edge - left_edge;
  assign found    = (pattern_length != '0) && best_valid;

  always_comb begin
    need_rd_en   = 1'b0;
    need_rd_addr = sym_red;
    need_wr_en   = 1'b0;
    need_wr_data = need_rd + NEED_W'(1);
    missing_next = missing_count;
    case (state)
      ST_IDLE: begin
        need_rd_en = take_pat || take_txt;
      end
      ST_P_UPD: begin
        need_wr_en = 1'b1;
      end
      ST_T_UPD: begin
        need_wr_en   = 1'b1;
        need_wr_data = need_rd - NEED_W'(1);
        if (need_rd > 0) begin
          missing_next = missing_count - LEN_W'(1);
        end
      end
      ST_L_SYM: begin
        need_rd_en   = 1'b1;
        need_rd_addr = text_rd;
      end
      ST_L_UPD: begin
        need_wr_en = 1'b1;
        if (need_rd == 0) begin
          missing_next = missing_count + LEN_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // The window shrinks while every pattern character is still covered.
  assign scan_go = (missing_next == '0) && (pattern_length != '0) && (left_edge < right_edge);

  mwss_need_tab #(
    .DEPTH (ALPHABET),
    .WIDTH (NEED_W)
  ) u_need_tab (
    .clk     (clk),
    .rst     (rst),
    .clear   (finish_acc),
    .rd_en   (need_rd_en),
    .rd_addr (need_rd_addr),
    .rd_data (need_rd),
    .wr_en   (need_wr_en),
    .wr_addr (cur_sym),
    .wr_data (need_wr_data)
  );

  always_ff @(posedge clk) begin
    if (take_txt) begin
      text_store[right_edge[IDX_W-1:0]] <= sym_red;
    end
    if ((state == ST_T_UPD || state == ST_L_UPD) && scan_go) begin
      text_rd <= text_store[left_edge[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      missing_count  <= '0;
      pattern_length <= '0;
      left_edge      <= '0;
      right_edge     <= '0;
      best_start     <= '0;
      best_length    <= '0;
      best_valid     <= 1'b0;
      overflow_flag  <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !finish_acc) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (s_tuser)
              REQ_PATTERN: begin
                if (take_pat) begin
                  cur_sym <= sym_red;
                  state   <= ST_P_UPD;
                end else begin
                  overflow_flag <= 1'b1;
                end
              end
              REQ_TEXT: begin
                if (take_txt) begin
                  cur_sym    <= sym_red;
                  right_edge <= right_edge + LEN_W'(1);
                  state      <= ST_T_UPD;
                end else begin
                  overflow_flag <= 1'b1;
                end
              end
              REQ_FINISH: begin
                m_tvalid <= 1'b1;
                m_tdata  <= {{OUT_PAD_W{1'b0}}, overflow_flag,
                             found ? LENGTH_W'(best_length) : {LENGTH_W{1'b0}},
                             found ? START_W'(best_start) : {START_W{1'b0}},
                             found};
                missing_count  <= '0;
                pattern_length <= '0;
                left_edge      <= '0;
                right_edge     <= '0;
                best_start     <= '0;
                best_length    <= '0;
                best_valid     <= 1'b0;
                overflow_flag  <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_P_UPD: begin
          missing_count  <= missing_count + LEN_W'(1);
          pattern_length <= pattern_length + LEN_W'(1);
          state          <= ST_IDLE;
        end
        ST_T_UPD, ST_L_UPD: begin
          missing_count <= missing_next;
          state         <= scan_go ? ST_L_SYM : ST_IDLE;
        end
        ST_L_SYM: begin
          // A later window replaces the best only when strictly shorter.
          if (!best_valid || span < best_length) begin
            best_start  <= left_edge[IDX_W-1:0];
            best_length <= span;
            best_valid  <= 1'b1;
          end
          cur_sym   <= text_rd;
          left_edge <= left_edge + LEN_W'(1);
          state     <= ST_L_UPD;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
